>>> src/bst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bst_pkg: shared types and constants of the byte stream tokenizer
// Token kinds, character codes, character classes and the token beat layout.
// ----------------------------------------------------------------------------
package bst_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;

   // results per input byte and depth of the token queue
   localparam int MAX_TOKENS     = 3;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] KIND_IDENT  = 4'd0;
   localparam logic [3:0] KIND_INT    = 4'd1;
   localparam logic [3:0] KIND_REAL   = 4'd2;
   localparam logic [3:0] KIND_STRING = 4'd3;
   localparam logic [3:0] KIND_SINGLE = 4'd4;
   localparam logic [3:0] KIND_ADD_EQ = 4'd5;
   localparam logic [3:0] KIND_SUB_EQ = 4'd6;
   localparam logic [3:0] KIND_MUL_EQ = 4'd7;
   localparam logic [3:0] KIND_DIV_EQ = 4'd8;
   localparam logic [3:0] KIND_EQ_EQ  = 4'd9;
   localparam logic [3:0] KIND_NOT_EQ = 4'd10;
   localparam logic [3:0] KIND_LE     = 4'd11;
   localparam logic [3:0] KIND_GE     = 4'd12;
   localparam logic [3:0] KIND_EOF    = 4'd13;
   localparam logic [3:0] KIND_NONE   = 4'd0;

   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_LF         = 8'h0A;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_BANG       = 8'h21;
   localparam logic [7:0] CHAR_QUOTE      = 8'h22;
   localparam logic [7:0] CHAR_HASH       = 8'h23;
   localparam logic [7:0] CHAR_STAR       = 8'h2A;
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] CHAR_SLASH      = 8'h2F;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_NINE       = 8'h39;
   localparam logic [7:0] CHAR_LESS       = 8'h3C;
   localparam logic [7:0] CHAR_EQUALS     = 8'h3D;
   localparam logic [7:0] CHAR_GREATER    = 8'h3E;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_E_UPPER    = 8'h45;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_E_LOWER    = 8'h65;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [7:0]  char_code;
      logic [31:0] begin_offset;
      logic [31:0] end_offset;
      logic [1:0]  error_count;
      logic        last_result;
   } token_type;

   // tokens produced by one accepted byte, slot 0 first
   typedef struct packed {
      logic [1:0]                       count;
      token_type [MAX_TOKENS-1:0]       tokens;
   } scan_push_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
             ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   // kind of the two-character operator that c opens, KIND_NONE if none
   function automatic logic [3:0] oper_kind(input logic [7:0] c);
      logic [3:0] k;
      case (c)
         CHAR_PLUS:    k = KIND_ADD_EQ;
         CHAR_MINUS:   k = KIND_SUB_EQ;
         CHAR_STAR:    k = KIND_MUL_EQ;
         CHAR_SLASH:   k = KIND_DIV_EQ;
         CHAR_EQUALS:  k = KIND_EQ_EQ;
         CHAR_BANG:    k = KIND_NOT_EQ;
         CHAR_LESS:    k = KIND_LE;
         CHAR_GREATER: k = KIND_GE;
         default:      k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

>>> src/bst_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bst_stream_if: valid/ready channels of the byte stream tokenizer
// Text byte channel and token channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface bst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface bst_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [7:0]  char_code;
   logic [31:0] begin_offset;
   logic [31:0] end_offset;
   logic [1:0]  error_count;
   logic        last_result;

   modport source (output valid, output token_kind, output char_code,
                   output begin_offset, output end_offset, output error_count,
                   output last_result, input ready);
   modport sink   (input valid, input token_kind, input char_code,
                   input begin_offset, input end_offset, input error_count,
                   input last_result, output ready);
endinterface
`default_nettype wire

>>> src/bst_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bst_scanner: scan state and per-byte token logic
// Holds the scan state; for each accepted byte works out up to three tokens
// and the next state in one pass.
// ----------------------------------------------------------------------------
module bst_scanner
   import bst_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire logic [7:0]    text_byte,
   input  wire logic          end_of_text,
   output scan_push_type      push
);

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUM,
      MODE_EXP_E,
      MODE_EXP_SIGN,
      MODE_EXP_DIG,
      MODE_COMMENT,
      MODE_STRING,
      MODE_DOT,
      MODE_OPER
   } mode_type;

   typedef logic [OFFSET_BITS-1:0] offset_type;

   mode_type   mode_ff,     mode_in;
   offset_type position_ff, position_in;
   offset_type tstart_ff,   tstart_in;
   logic [7:0] held_ff,     held_in;
   logic [1:0] dots_ff,     dots_in;
   logic       real_ff,     real_in;
   logic [1:0] errs_ff,     errs_in;
   offset_type pend_ff,     pend_in;

   token_type [MAX_TOKENS-1:0] tok_v;
   logic [1:0]                 n_v;

   function automatic token_type make_token(input logic [3:0] kind,
                                            input logic [7:0] code,
                                            input offset_type b,
                                            input offset_type e,
                                            input logic [1:0] err);
      token_type  t;
      logic [63:0] b_w;
      logic [63:0] e_w;
      b_w = 64'(b);
      e_w = 64'(e);
      t.token_kind   = kind;
      t.char_code    = code;
      t.begin_offset = b_w[31:0];
      t.end_offset   = e_w[31:0];
      t.error_count  = err;
      t.last_result  = 1'b0;
      return t;
   endfunction

   function automatic logic [1:0] sat_inc(input logic [1:0] v);
      return (v == 2'd3) ? v : v + 2'd1;
   endfunction

   always_comb begin
      logic [7:0] c;
      offset_type p;
      offset_type p1;
      logic       again;
      logic [3:0] nkind;

      c       = text_byte;
      p       = position_ff;
      p1      = position_ff + OFFSET_BITS'(1);
      again   = 1'b0;
      nkind   = KIND_INT;
      mode_in = mode_ff;
      tstart_in = tstart_ff;
      held_in = held_ff;
      dots_in = dots_ff;
      real_in = real_ff;
      errs_in = errs_ff;
      pend_in = pend_ff;
      tok_v   = '0;
      n_v     = 2'd0;

      unique case (mode_ff)
         MODE_IDLE: begin
            again = 1'b1;
         end
         MODE_IDENT: begin
            if (!(is_alpha(c) || is_digit(c) || c == CHAR_UNDERSCORE)) begin
               tok_v[n_v] = make_token(KIND_IDENT, 8'd0, tstart_in, p, errs_in);
               n_v = n_v + 2'd1;
               pend_in = p;
               mode_in = MODE_IDLE;
               again = 1'b1;
            end
         end
         MODE_NUM: begin
            if (c == CHAR_DOT) begin
               if (dots_in == 2'd1) errs_in = sat_inc(errs_in);
               if (dots_in < 2'd2) dots_in = dots_in + 2'd1;
            end else if (c == CHAR_E_LOWER || c == CHAR_E_UPPER) begin
               real_in = 1'b1;
               mode_in = MODE_EXP_E;
            end else if (!is_digit(c)) begin
               nkind = (dots_in != 2'd0 || real_in) ? KIND_REAL : KIND_INT;
               tok_v[n_v] = make_token(nkind, 8'd0, tstart_in, p, errs_in);
               n_v = n_v + 2'd1;
               pend_in = p;
               mode_in = MODE_IDLE;
               again = 1'b1;
            end
         end
         MODE_EXP_E: begin
            if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               mode_in = MODE_EXP_SIGN;
            end else begin
               if (!is_digit(c)) errs_in = sat_inc(errs_in);
               mode_in = MODE_EXP_DIG;
            end
         end
         MODE_EXP_SIGN: begin
            if (is_digit(c)) begin
               mode_in = MODE_EXP_DIG;
            end else begin
               errs_in = sat_inc(errs_in);
               nkind = (dots_in != 2'd0 || real_in) ? KIND_REAL : KIND_INT;
               tok_v[n_v] = make_token(nkind, 8'd0, tstart_in, p, errs_in);
               n_v = n_v + 2'd1;
               pend_in = p;
               mode_in = MODE_IDLE;
               again = 1'b1;
            end
         end
         MODE_EXP_DIG: begin
            if (!is_digit(c)) begin
               nkind = (dots_in != 2'd0 || real_in) ? KIND_REAL : KIND_INT;
               tok_v[n_v] = make_token(nkind, 8'd0, tstart_in, p, errs_in);
               n_v = n_v + 2'd1;
               pend_in = p;
               mode_in = MODE_IDLE;
               again = 1'b1;
            end
         end
         MODE_COMMENT: begin
            if (c == CHAR_NUL || c == CHAR_LF || c == CHAR_CR) begin
               pend_in = p;
               mode_in = MODE_IDLE;
               again = 1'b1;
            end
         end
         MODE_STRING: begin
            if (c == CHAR_QUOTE) begin
               tok_v[n_v] = make_token(KIND_STRING, 8'd0, tstart_in, p1, errs_in);
               n_v = n_v + 2'd1;
               pend_in = p1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_DOT: begin
            if (is_digit(c)) begin
               mode_in = MODE_NUM;
               dots_in = 2'd1;
            end else begin
               tok_v[n_v] = make_token(KIND_SINGLE, held_in, tstart_in,
                                       tstart_in + OFFSET_BITS'(1), 2'd0);
               n_v = n_v + 2'd1;
               pend_in = tstart_in + OFFSET_BITS'(1);
               mode_in = MODE_IDLE;
               again = 1'b1;
            end
         end
         MODE_OPER: begin
            if (c == CHAR_EQUALS) begin
               tok_v[n_v] = make_token(oper_kind(held_in), 8'd0, tstart_in, p1, 2'd0);
               n_v = n_v + 2'd1;
               pend_in = p1;
               mode_in = MODE_IDLE;
            end else begin
               tok_v[n_v] = make_token(KIND_SINGLE, held_in, tstart_in,
                                       tstart_in + OFFSET_BITS'(1), 2'd0);
               n_v = n_v + 2'd1;
               pend_in = tstart_in + OFFSET_BITS'(1);
               mode_in = MODE_IDLE;
               again = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            again = 1'b1;
         end
      endcase

      // byte not taken by the open token: scan it as the start of a new one
      if (again) begin
         if (is_space(c)) begin
            mode_in = mode_in;
         end else if (is_alpha(c) || is_digit(c) || c == CHAR_DOT || c == CHAR_HASH ||
                      c == CHAR_QUOTE || oper_kind(c) != KIND_NONE) begin
            tstart_in = p;
            dots_in = 2'd0;
            real_in = 1'b0;
            errs_in = 2'd0;
            if (is_alpha(c)) begin
               mode_in = MODE_IDENT;
            end else if (is_digit(c)) begin
               mode_in = MODE_NUM;
            end else if (c == CHAR_DOT) begin
               mode_in = MODE_DOT;
               held_in = c;
            end else if (c == CHAR_HASH) begin
               mode_in = MODE_COMMENT;
            end else if (c == CHAR_QUOTE) begin
               mode_in = MODE_STRING;
            end else begin
               mode_in = MODE_OPER;
               held_in = c;
            end
         end else begin
            tok_v[n_v] = make_token(KIND_SINGLE, c, p, p1, 2'd0);
            n_v = n_v + 2'd1;
            pend_in = p1;
         end
      end

      // last byte of the buffer: close what is open, then the end of file
      if (end_of_text) begin
         unique case (mode_in)
            MODE_IDENT: begin
               tok_v[n_v] = make_token(KIND_IDENT, 8'd0, tstart_in, p1, errs_in);
               n_v = n_v + 2'd1;
               pend_in = p1;
            end
            MODE_NUM, MODE_EXP_E, MODE_EXP_SIGN, MODE_EXP_DIG: begin
               if (mode_in == MODE_EXP_E || mode_in == MODE_EXP_SIGN) begin
                  errs_in = sat_inc(errs_in);
               end
               nkind = (dots_in != 2'd0 || real_in) ? KIND_REAL : KIND_INT;
               tok_v[n_v] = make_token(nkind, 8'd0, tstart_in, p1, errs_in);
               n_v = n_v + 2'd1;
               pend_in = p1;
            end
            MODE_COMMENT: begin
               pend_in = p1;
            end
            MODE_STRING: begin
               errs_in = sat_inc(errs_in);
               tok_v[n_v] = make_token(KIND_STRING, 8'd0, tstart_in, p1, errs_in);
               n_v = n_v + 2'd1;
               pend_in = p1;
            end
            MODE_DOT, MODE_OPER: begin
               tok_v[n_v] = make_token(KIND_SINGLE, held_in, tstart_in,
                                       tstart_in + OFFSET_BITS'(1), 2'd0);
               n_v = n_v + 2'd1;
               pend_in = tstart_in + OFFSET_BITS'(1);
            end
            default: begin
               pend_in = pend_in;
            end
         endcase
         tok_v[n_v] = make_token(KIND_EOF, 8'd0, pend_in, pend_in + OFFSET_BITS'(1), 2'd0);
         n_v = n_v + 2'd1;

         mode_in   = MODE_IDLE;
         position_in = '0;
         tstart_in = '0;
         held_in   = 8'd0;
         dots_in   = 2'd0;
         real_in   = 1'b0;
         errs_in   = 2'd0;
         pend_in   = '0;
      end else begin
         position_in = p1;
      end

      if (n_v != 2'd0) tok_v[n_v - 2'd1].last_result = 1'b1;
   end

   assign push.count  = accept ? n_v : 2'd0;
   assign push.tokens = tok_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         position_ff <= '0;
         tstart_ff   <= '0;
         held_ff     <= 8'd0;
         dots_ff     <= 2'd0;
         real_ff     <= 1'b0;
         errs_ff     <= 2'd0;
         pend_ff     <= '0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         position_ff <= position_in;
         tstart_ff   <= tstart_in;
         held_ff     <= held_in;
         dots_ff     <= dots_in;
         real_ff     <= real_in;
         errs_ff     <= errs_in;
         pend_ff     <= pend_in;
      end
   end

endmodule
`default_nettype wire

>>> src/bst_token_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bst_token_queue: token queue between scanner and token channel
// Takes up to three tokens per cycle, hands out one token beat per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module bst_token_queue
   import bst_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire scan_push_type push,
   input  wire logic          out_ready,
   output logic               out_valid,
   output token_type          out_token,
   output logic               room
);

   token_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff,  count_in;
   logic                      pop;

   assign out_valid = (count_ff != '0);
   assign out_token = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // room for a full burst of tokens, counting the beat leaving this cycle
   assign room = (count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH - MAX_TOKENS)) ||
                 (pop && count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH - MAX_TOKENS + 1));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
      count_in  = count_ff + QUEUE_CNT_BITS'(push.count) - QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_TOKENS; i++) begin
         if (2'(i) < push.count) begin
            entry_ff[wr_ptr_ff + QUEUE_PTR_BITS'(i)] <= push.tokens[i];
         end
      end
   end

endmodule
`default_nettype wire

>>> src/byte_stream_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stream_tokenizer: lexical scanner over a byte stream
// Turns source text, one byte per beat, into tokens with byte offsets.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one text byte per beat; end_of_text marks the last byte
//   of a buffer. rsp_bus carries one token per beat; last_result marks the
//   final token caused by a given byte.
//   Each byte is scanned in the cycle it is accepted and its tokens (zero to
//   three) sit in a four-entry token queue, so a token can reach rsp_bus
//   at the earliest in the cycle after its byte is taken.
//   Throughput is one byte per cycle while bytes give at most one token each
//   and rsp_bus.ready stays high; a byte giving two or three tokens costs that
//   many token beats on rsp_bus, the single token port being the limit.
//   req_bus.ready stays high while the queue can take a full burst of three,
//   so a token waiting on a stalled receiver does not block the next byte;
//   a longer stall fills the queue and drops ready until beats drain.
//   After the end_of_text byte the scan state returns to its reset value and
//   the next byte opens a new buffer at offset zero.
//   Reset is synchronous: it empties the queue and clears the scan state.
// ----------------------------------------------------------------------------
module byte_stream_tokenizer
   import bst_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bst_req_if.sink    req_bus,
   bst_rsp_if.source  rsp_bus
);

   scan_push_type push;
   token_type     head;
   logic          room;
   logic          accept;

   assign req_bus.ready = room;
   assign accept        = req_bus.valid && room;

   bst_scanner #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scanner (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_bus.text_byte),
      .end_of_text (req_bus.end_of_text),
      .push        (push)
   );

   bst_token_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_ready (rsp_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_token (head),
      .room      (room)
   );

   assign rsp_bus.token_kind   = head.token_kind;
   assign rsp_bus.char_code    = head.char_code;
   assign rsp_bus.begin_offset = head.begin_offset;
   assign rsp_bus.end_offset   = head.end_offset;
   assign rsp_bus.error_count  = head.error_count;
   assign rsp_bus.last_result  = head.last_result;

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the byte stream tokenizer
// A driver pushes text buffers, short directed ones and then random buffers
// built from token fragments, through the byte channel. A monitor scores each
// token beat against a scanner model kept here, with bursty sending and a
// stalling receiver, including one long hold-off that backs up the block.
// ----------------------------------------------------------------------------
module tb_top;
   import bst_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_BYTES   = 96;
   localparam int DRAIN_CYCLES   = 16;
   localparam int REPORT_LIMIT   = 10;
   localparam int HOLDOFF_AFTER  = 60;
   localparam int HOLDOFF_CYCLES = 48;

   localparam int STALL_NONE  = 0;
   localparam int STALL_HALF  = 1;
   localparam int STALL_HEAVY = 2;

   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_EXP_MARK, SCAN_EXP_SIGN,
      SCAN_EXP_DIGITS, SCAN_COMMENT, SCAN_STRING, SCAN_DOT, SCAN_OPERATOR
   } scan_state_type;

   typedef enum int {
      FRAG_IDENT, FRAG_INT, FRAG_REAL, FRAG_EXP, FRAG_DOT, FRAG_STRING,
      FRAG_COMMENT, FRAG_OPER, FRAG_SPACE, FRAG_NOISE
   } frag_type;

   typedef struct packed {
      logic [7:0] text;
      logic       eot;
   } text_beat_type;

   logic clock = 1'b0;
   logic reset;

   bst_req_if req_bus ();
   bst_rsp_if rsp_bus ();

   byte_stream_tokenizer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   text_beat_type pending_bytes[$];
   logic [7:0]    text_buf[$];
   token_type     expected_tokens[$];
   token_type     step_tokens[$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int bytes_taken    = 0;
   int gap_left       = 0;
   int burst_left     = 0;
   int holdoff_left   = 0;
   bit holdoff_done   = 1'b0;
   int stall_mode     = STALL_NONE;
   int pattern_left   = 0;

   // scanner model state
   scan_state_type lex_state;
   logic [31:0]    lex_pos;
   logic [31:0]    lex_start;
   logic [31:0]    lex_prev_end;
   logic [7:0]     lex_held;
   logic [1:0]     lex_dots;
   logic           lex_real;
   logic [1:0]     lex_errors;

   // ------------------------------------------------------------------
   // scanner model
   // ------------------------------------------------------------------
   function automatic logic digit_char(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic logic letter_char(input logic [7:0] c);
      return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z);
   endfunction

   function automatic logic [3:0] op_kind_of(input logic [7:0] c);
      case (c)
         CHAR_PLUS:    return KIND_ADD_EQ;
         CHAR_MINUS:   return KIND_SUB_EQ;
         CHAR_STAR:    return KIND_MUL_EQ;
         CHAR_SLASH:   return KIND_DIV_EQ;
         CHAR_EQUALS:  return KIND_EQ_EQ;
         CHAR_BANG:    return KIND_NOT_EQ;
         CHAR_LESS:    return KIND_LE;
         CHAR_GREATER: return KIND_GE;
         default:      return KIND_NONE;
      endcase
   endfunction

   function automatic void clear_scan();
      lex_state    = SCAN_IDLE;
      lex_pos      = '0;
      lex_start    = '0;
      lex_prev_end = '0;
      lex_held     = '0;
      lex_dots     = '0;
      lex_real     = 1'b0;
      lex_errors   = '0;
   endfunction

   function automatic void emit_token(input logic [3:0] kind, input logic [7:0] code,
                                      input logic [31:0] b, input logic [31:0] e,
                                      input logic [1:0] err);
      token_type t;
      t.token_kind   = kind;
      t.char_code    = code;
      t.begin_offset = b;
      t.end_offset   = e;
      t.error_count  = err;
      t.last_result  = 1'b0;
      step_tokens.push_back(t);
      lex_prev_end = e;
   endfunction

   function automatic void add_error();
      if (lex_errors != 2'd3) lex_errors = lex_errors + 2'd1;
   endfunction

   function automatic void open_token(input scan_state_type m, input logic [31:0] p);
      lex_state  = m;
      lex_start  = p;
      lex_dots   = '0;
      lex_real   = 1'b0;
      lex_errors = '0;
   endfunction

   function automatic void close_number(input logic [31:0] e);
      emit_token((lex_dots != 0 || lex_real) ? KIND_REAL : KIND_INT, 8'h00,
                 lex_start, e, lex_errors);
      lex_state = SCAN_IDLE;
   endfunction

   function automatic void emit_held();
      emit_token(KIND_SINGLE, lex_held, lex_start, lex_start + 32'd1, 2'd0);
      lex_state = SCAN_IDLE;
   endfunction

   // tokens caused by one accepted text byte, appended to the expected store
   function automatic void scan_byte(input logic [7:0] c, input logic last);
      logic [31:0] p;
      logic [31:0] p1;
      logic        rescan;
      token_type   t;
      p      = lex_pos;
      p1     = lex_pos + 32'd1;
      rescan = 1'b0;
      step_tokens.delete();
      case (lex_state)
         SCAN_IDENT: begin
            if (!(letter_char(c) || digit_char(c) || c == CHAR_UNDERSCORE)) begin
               emit_token(KIND_IDENT, 8'h00, lex_start, p, lex_errors);
               lex_state = SCAN_IDLE;
               rescan    = 1'b1;
            end
         end
         SCAN_NUMBER: begin
            if (c == CHAR_DOT) begin
               if (lex_dots == 2'd1) add_error();
               if (lex_dots < 2'd2) lex_dots = lex_dots + 2'd1;
            end else if (c == CHAR_E_LOWER || c == CHAR_E_UPPER) begin
               lex_real  = 1'b1;
               lex_state = SCAN_EXP_MARK;
            end else if (!digit_char(c)) begin
               close_number(p);
               rescan = 1'b1;
            end
         end
         SCAN_EXP_MARK: begin
            if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               lex_state = SCAN_EXP_SIGN;
            end else begin
               if (!digit_char(c)) add_error();
               lex_state = SCAN_EXP_DIGITS;
            end
         end
         SCAN_EXP_SIGN: begin
            if (digit_char(c)) begin
               lex_state = SCAN_EXP_DIGITS;
            end else begin
               add_error();
               close_number(p);
               rescan = 1'b1;
            end
         end
         SCAN_EXP_DIGITS: begin
            if (!digit_char(c)) begin
               close_number(p);
               rescan = 1'b1;
            end
         end
         SCAN_COMMENT: begin
            if (c == CHAR_NUL || c == CHAR_LF || c == CHAR_CR) begin
               lex_prev_end = p;
               lex_state    = SCAN_IDLE;
               rescan       = 1'b1;
            end
         end
         SCAN_STRING: begin
            if (c == CHAR_QUOTE) begin
               emit_token(KIND_STRING, 8'h00, lex_start, p1, lex_errors);
               lex_state = SCAN_IDLE;
            end
         end
         SCAN_DOT: begin
            if (digit_char(c)) begin
               lex_state = SCAN_NUMBER;
               lex_dots  = 2'd1;
            end else begin
               emit_held();
               rescan = 1'b1;
            end
         end
         SCAN_OPERATOR: begin
            if (c == CHAR_EQUALS) begin
               emit_token(op_kind_of(lex_held), 8'h00, lex_start, p1, 2'd0);
               lex_state = SCAN_IDLE;
            end else begin
               emit_held();
               rescan = 1'b1;
            end
         end
         default: begin
            lex_state = SCAN_IDLE;
            rescan    = 1'b1;
         end
      endcase

      // byte seen afresh from the idle state
      if (rescan) begin
         if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
         end else if (letter_char(c)) begin
            open_token(SCAN_IDENT, p);
         end else if (digit_char(c)) begin
            open_token(SCAN_NUMBER, p);
         end else if (c == CHAR_DOT) begin
            open_token(SCAN_DOT, p);
            lex_held = c;
         end else if (c == CHAR_HASH) begin
            open_token(SCAN_COMMENT, p);
         end else if (c == CHAR_QUOTE) begin
            open_token(SCAN_STRING, p);
         end else if (op_kind_of(c) != KIND_NONE) begin
            open_token(SCAN_OPERATOR, p);
            lex_held = c;
         end else begin
            emit_token(KIND_SINGLE, c, p, p1, 2'd0);
         end
      end

      if (last) begin
         case (lex_state)
            SCAN_IDENT: emit_token(KIND_IDENT, 8'h00, lex_start, p1, lex_errors);
            SCAN_EXP_MARK, SCAN_EXP_SIGN: begin
               add_error();
               close_number(p1);
            end
            SCAN_NUMBER, SCAN_EXP_DIGITS: close_number(p1);
            SCAN_COMMENT: lex_prev_end = p1;
            SCAN_STRING: begin
               add_error();
               emit_token(KIND_STRING, 8'h00, lex_start, p1, lex_errors);
            end
            SCAN_DOT, SCAN_OPERATOR: emit_held();
            default: begin
            end
         endcase
         emit_token(KIND_EOF, 8'h00, lex_prev_end, lex_prev_end + 32'd1, 2'd0);
         clear_scan();
      end else begin
         lex_pos = p1;
      end

      if (step_tokens.size() != 0) begin
         t = step_tokens.pop_back();
         t.last_result = 1'b1;
         step_tokens.push_back(t);
      end
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(0, 51);
      return (r < 26) ? 8'(CHAR_UPPER_A + r) : 8'(CHAR_LOWER_A + r - 26);
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'(CHAR_ZERO + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_oper();
      case ($urandom_range(0, 7))
         0:       return CHAR_PLUS;
         1:       return CHAR_MINUS;
         2:       return CHAR_STAR;
         3:       return CHAR_SLASH;
         4:       return CHAR_EQUALS;
         5:       return CHAR_BANG;
         6:       return CHAR_LESS;
         default: return CHAR_GREATER;
      endcase
   endfunction

   function automatic logic [7:0] rand_blank();
      int r;
      r = $urandom_range(0, 5);
      return (r == 5) ? CHAR_SPACE : 8'(CHAR_TAB + r);
   endfunction

   function automatic void add_digits(input int lo, input int hi);
      int n;
      n = $urandom_range(lo, hi);
      repeat (n) text_buf.push_back(rand_digit());
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   // moves the text buffer to the byte queue, last byte marked end of text
   function automatic void send_buffer();
      text_beat_type b;
      foreach (text_buf[i]) begin
         b.text = text_buf[i];
         b.eot  = (i == text_buf.size() - 1);
         pending_bytes.push_back(b);
      end
      text_buf.delete();
   endfunction

   function automatic void add_fragment(input frag_type kind);
      logic [7:0] b;
      int         n;
      case (kind)
         FRAG_IDENT: begin
            text_buf.push_back(rand_letter());
            n = $urandom_range(0, 5);
            repeat (n) begin
               case ($urandom_range(0, 2))
                  0:       text_buf.push_back(rand_letter());
                  1:       text_buf.push_back(rand_digit());
                  default: text_buf.push_back(CHAR_UNDERSCORE);
               endcase
            end
         end
         FRAG_INT: add_digits(1, 4);
         FRAG_REAL: begin
            add_digits(1, 3);
            n = $urandom_range(1, 3);
            repeat (n) begin
               text_buf.push_back(CHAR_DOT);
               add_digits(0, 2);
            end
         end
         FRAG_EXP: begin
            add_digits(1, 3);
            if ($urandom_range(0, 2) == 0) text_buf.push_back(CHAR_DOT);
            text_buf.push_back($urandom_range(0, 1) ? CHAR_E_LOWER : CHAR_E_UPPER);
            case ($urandom_range(0, 3))
               0: add_digits(1, 2);
               1: begin
                  text_buf.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                  add_digits(1, 2);
               end
               2: begin
                  text_buf.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                  text_buf.push_back(rand_letter());
               end
               default: begin
                  text_buf.push_back(rand_letter());
                  add_digits(0, 2);
               end
            endcase
         end
         FRAG_DOT: begin
            text_buf.push_back(CHAR_DOT);
            if ($urandom_range(0, 1)) add_digits(1, 3);
            else text_buf.push_back(8'($urandom_range(0, 255)));
         end
         FRAG_STRING: begin
            text_buf.push_back(CHAR_QUOTE);
            n = $urandom_range(0, 5);
            repeat (n) begin
               do b = 8'($urandom_range(0, 255)); while (b == CHAR_QUOTE);
               text_buf.push_back(b);
            end
            text_buf.push_back(CHAR_QUOTE);
         end
         FRAG_COMMENT: begin
            text_buf.push_back(CHAR_HASH);
            n = $urandom_range(0, 5);
            repeat (n) begin
               do b = 8'($urandom_range(0, 255));
               while (b == CHAR_NUL || b == CHAR_LF || b == CHAR_CR);
               text_buf.push_back(b);
            end
            case ($urandom_range(0, 2))
               0:       text_buf.push_back(CHAR_NUL);
               1:       text_buf.push_back(CHAR_LF);
               default: text_buf.push_back(CHAR_CR);
            endcase
         end
         FRAG_OPER: begin
            text_buf.push_back(rand_oper());
            if ($urandom_range(0, 2) != 0) text_buf.push_back(CHAR_EQUALS);
         end
         FRAG_SPACE: begin
            n = $urandom_range(1, 3);
            repeat (n) text_buf.push_back(rand_blank());
         end
         default: text_buf.push_back(8'($urandom_range(0, 255)));
      endcase
   endfunction

   function automatic string token_text(input token_type t);
      return $sformatf("kind %0d code %02h begin %0d end %0d err %0d last %0d",
                       t.token_kind, t.char_code, t.begin_offset, t.end_offset,
                       t.error_count, t.last_result);
   endfunction

   function automatic void note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
   endfunction

   // ------------------------------------------------------------------
   // driver: bursts of byte beats with random gaps
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.text_byte   <= '0;
         req_bus.end_of_text <= 1'b0;
         gap_left            <= 0;
         burst_left          <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            void'(pending_bytes.pop_front());
            bytes_taken <= bytes_taken + 1;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // beat held until taken
         end else if (gap_left != 0 && holdoff_left == 0) begin
            gap_left      <= gap_left - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            req_bus.valid       <= 1'b1;
            req_bus.text_byte   <= pending_bytes[0].text;
            req_bus.end_of_text <= pending_bytes[0].eot;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: stall pattern switching at random intervals, plus one
   // long hold-off so the token queue fills and the byte side backs up
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left  <= holdoff_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!holdoff_done && bytes_taken >= HOLDOFF_AFTER) begin
         holdoff_done  <= 1'b1;
         holdoff_left  <= HOLDOFF_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            stall_mode   <= $urandom_range(STALL_NONE, STALL_HEAVY);
            pattern_left <= $urandom_range(8, 40);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (stall_mode)
            STALL_NONE: rsp_bus.ready <= 1'b1;
            STALL_HALF: rsp_bus.ready <= 1'($urandom_range(0, 1));
            default:    rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // monitor: score token beats first, then model the byte taken this edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      token_type seen;
      token_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.token_kind   = rsp_bus.token_kind;
            seen.char_code    = rsp_bus.char_code;
            seen.begin_offset = rsp_bus.begin_offset;
            seen.end_offset   = rsp_bus.end_offset;
            seen.error_count  = rsp_bus.error_count;
            seen.last_result  = rsp_bus.last_result;
            if (expected_tokens.size() == 0) begin
               note_failure({"unexpected token: ", token_text(seen)});
            end else begin
               want = expected_tokens.pop_front();
               if (seen.token_kind !== want.token_kind ||
                   seen.char_code !== want.char_code ||
                   seen.begin_offset !== want.begin_offset ||
                   seen.end_offset !== want.end_offset ||
                   seen.error_count !== want.error_count ||
                   seen.last_result !== want.last_result)
                  note_failure({"token mismatch: expected ", token_text(want),
                                ", got ", token_text(seen)});
            end
         end
         if (req_bus.valid && req_bus.ready)
            scan_byte(req_bus.text_byte, req_bus.end_of_text);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("byte_stream_tokenizer verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int       start_size;
      int       frags;
      int       cut;
      frag_type kind;
      reset = 1'b1;
      clear_scan();

      // directed: identifier, tab, multi-dot real with signed exponent,
      // lone dot, '!=', string, '<' without '=', top byte, comment cut by
      // NUL, then an exponent left open at end of text
      add_text("Ab_9\t3.4.5E+7 .x!=\"q\"<");
      text_buf.push_back(8'hFF);
      send_buffer();
      add_text("#");
      text_buf.push_back(CHAR_NUL);
      send_buffer();
      add_text("9e");
      send_buffer();

      // random buffers of fragments; some end part-way through a token
      start_size = pending_bytes.size();
      while (pending_bytes.size() - start_size < RANDOM_BYTES) begin
         frags = $urandom_range(1, 6);
         cut   = 0;
         repeat (frags) begin
            if (text_buf.size() != 0 && $urandom_range(0, 1)) add_fragment(FRAG_SPACE);
            cut  = text_buf.size();
            kind = frag_type'($urandom_range(FRAG_IDENT, FRAG_NOISE));
            add_fragment(kind);
         end
         if ($urandom_range(0, 2) == 0) begin
            cut = $urandom_range(cut + 1, text_buf.size());
            while (text_buf.size() > cut) void'(text_buf.pop_back());
         end
         send_buffer();
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_bytes.size() != 0 || expected_tokens.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_tokens.size() != 0)
         note_failure($sformatf("%0d tokens never arrived", expected_tokens.size()));

      if (mismatch_count == 0)
         $display("byte_stream_tokenizer verification clean");
      else
         $display("byte_stream_tokenizer verification failed");
      $finish;
   end

endmodule
`default_nettype wire

>>> filelist.f
src/bst_pkg.sv
src/bst_stream_if.sv
src/bst_scanner.sv
src/bst_token_queue.sv
src/byte_stream_tokenizer.sv
dv/tb_top.sv
